FILE: sv/assert_macros.svh
// assertion macros used by the checker module
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ukrt_pkg.sv
// types and constants of the keyed record table
// no dependencies; imported by the interfaces, the record memory, top level and checker
`timescale 1ns / 1ps

package ukrt_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int CNT_W_DEF    = $clog2(CAPACITY_DEF + 1);

  // operation codes of an input transaction
  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_DELETE = 3'd1,
    OP_READ   = 3'd2,
    OP_EXISTS = 3'd3,
    OP_LIST   = 3'd4,
    OP_STATUS = 3'd5
  } op_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_DUP   = 3'd2,
    ST_MISS  = 3'd3,
    ST_EMPTY = 3'd4
  } st_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_EMIT,
    S_LIST
  } state_t;

  // one stored record
  typedef struct packed {
    logic [31:0] key;
    logic [7:0]  year;
    logic [15:0] course_c;
    logic [15:0] course_b;
    logic [15:0] course_a;
    logic [7:0]  grade_c;
    logic [7:0]  grade_b;
    logic [7:0]  grade_a;
  } rec_t;

endpackage

FILE: sv/ukrt_if.sv
// valid/ready channel interfaces of the keyed record table
// depends on ukrt_pkg
`timescale 1ns / 1ps

interface ukrt_in_if
  import ukrt_pkg::*;
();
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] key;
  logic [7:0]  year;
  logic [15:0] course_a;
  logic [7:0]  grade_a;
  logic [15:0] course_b;
  logic [7:0]  grade_b;
  logic [15:0] course_c;
  logic [7:0]  grade_c;

  modport source (output valid, kind, key, year, course_a, grade_a, course_b, grade_b,
                  course_c, grade_c, input ready);
  modport sink   (input valid, kind, key, year, course_a, grade_a, course_b, grade_b,
                  course_c, grade_c, output ready);
endinterface

interface ukrt_out_if
  import ukrt_pkg::*;
#(
  parameter int CNT_W = CNT_W_DEF
) ();
  logic             valid;
  logic             ready;
  logic [2:0]       status;
  logic [31:0]      out_key;
  logic [7:0]       out_year;
  logic [15:0]      out_course_a;
  logic [7:0]       out_grade_a;
  logic [15:0]      out_course_b;
  logic [7:0]       out_grade_b;
  logic [15:0]      out_course_c;
  logic [7:0]       out_grade_c;
  logic [CNT_W-1:0] used_count;
  logic             is_full;
  logic             last;

  modport source (output valid, status, out_key, out_year, out_course_a, out_grade_a,
                  out_course_b, out_grade_b, out_course_c, out_grade_c, used_count,
                  is_full, last, input ready);
  modport sink   (input valid, status, out_key, out_year, out_course_a, out_grade_a,
                  out_course_b, out_grade_b, out_course_c, out_grade_c, used_count,
                  is_full, last, output ready);
endinterface

FILE: sv/ukrt_rec_mem.sv
// record memory: one write port, one read port, registered read data
// depends on ukrt_pkg
`timescale 1ns / 1ps

module ukrt_rec_mem
  import ukrt_pkg::*;
#(
  parameter int DEPTH = CAPACITY_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  rec_t          wr_data,
  input  logic [AW-1:0] rd_addr,
  output rec_t          rd_data
);

  rec_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: sv/unique_key_record_table.sv
// keyed record table top level: controller, output register, record memory
// depends on ukrt_pkg, ukrt_in_if, ukrt_out_if and ukrt_rec_mem
`timescale 1ns / 1ps

// Usage
//   in_ch carries one operation per transaction (add, delete, read, exists,
//   list keys, status); out_ch returns the results, each with used_count,
//   is_full and last. Kind codes 6 and 7 are dropped with no result.
//   Records sit in one single-port-read memory that is walked one entry per
//   cycle, so the key search sets the pace: status, list of an empty table
//   and add to a full table need no search; add, read, exists and delete
//   search up to used_count entries, and a delete moves the later entries
//   down after the hit; a list emits one result per cycle while out_ch
//   is not stalled. in_ch is ready only while no operation is in progress;
//   a finished result may still sit in the output register when the next
//   is taken. A stalled out_ch holds the result steady and stops the
//   controller before it loads the next one. Reset empties the table at
//   once through the fill count; the memory contents are never cleared.

module unique_key_record_table
  import ukrt_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ukrt_in_if.sink    in_ch,
  ukrt_out_if.source out_ch
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // controller registers
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [2:0]       op_r, op_nxt;
  logic [31:0]      key_r, key_nxt;
  rec_t             new_rec_r, new_rec_nxt;
  rec_t             res_rec_r, res_rec_nxt;
  st_t              res_st_r, res_st_nxt;
  logic             found_r, found_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  st_t              out_st_r, out_st_nxt;
  rec_t             out_rec_r, out_rec_nxt;
  logic [CNT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic             out_last_r, out_last_nxt;

  // memory ports
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  rec_t             wr_data;
  logic [AW-1:0]    rd_addr;
  rec_t             rd_data;

  logic             in_fire;
  logic             out_free;
  logic             tbl_full;
  logic [CNT_W:0]   idx_p1;
  logic [CNT_W:0]   idx_p2;
  logic [CNT_W:0]   cnt_ext;
  logic [CNT_W:0]   rd_sel;

  ukrt_rec_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ukrt_rec_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && (state_r == S_IDLE);
  assign out_free    = !out_valid_r || out_ch.ready;
  assign tbl_full    = (cnt_r == CNT_W'(CAPACITY));
  assign idx_p1      = {1'b0, idx_r} + (CNT_W + 1)'(1);
  assign idx_p2      = {1'b0, idx_r} + (CNT_W + 1)'(2);
  assign cnt_ext     = {1'b0, cnt_r};

  // read address follows the next index, one ahead while shifting down
  assign rd_sel  = (state_nxt == S_SHIFT) ? ({1'b0, idx_nxt} + (CNT_W + 1)'(1))
                                          : {1'b0, idx_nxt};
  assign rd_addr = rd_sel[AW-1:0];

  // next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    new_rec_nxt   = new_rec_r;
    res_rec_nxt   = res_rec_r;
    res_st_nxt    = res_st_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_st_nxt    = out_st_r;
    out_rec_nxt   = out_rec_r;
    out_cnt_nxt   = out_cnt_r;
    out_last_nxt  = out_last_r;
    wr_en         = 1'b0;
    wr_addr       = idx_r[AW-1:0];
    wr_data       = rd_data;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt               = in_ch.kind;
          key_nxt              = in_ch.key;
          new_rec_nxt.key      = in_ch.key;
          new_rec_nxt.year     = in_ch.year;
          new_rec_nxt.course_a = in_ch.course_a;
          new_rec_nxt.course_b = in_ch.course_b;
          new_rec_nxt.course_c = in_ch.course_c;
          new_rec_nxt.grade_a  = in_ch.grade_a;
          new_rec_nxt.grade_b  = in_ch.grade_b;
          new_rec_nxt.grade_c  = in_ch.grade_c;
          res_rec_nxt          = '0;
          found_nxt            = 1'b0;
          idx_nxt              = '0;
          case (in_ch.kind) inside
            OP_STATUS: begin
              res_st_nxt = ST_OK;
              state_nxt  = S_EMIT;
            end
            OP_LIST: begin
              if (cnt_r == '0) begin
                res_st_nxt = ST_EMPTY;
                state_nxt  = S_EMIT;
              end else begin
                state_nxt = S_LIST;
              end
            end
            OP_ADD, OP_DELETE, OP_READ, OP_EXISTS: begin
              if ((in_ch.kind == OP_ADD) && tbl_full) begin
                res_st_nxt = ST_FULL;
                state_nxt  = S_EMIT;
              end else if (cnt_r == '0) begin
                state_nxt = S_DECIDE;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      // compare one stored key per cycle
      S_SCAN: begin
        if (rd_data.key == key_r) begin
          found_nxt = 1'b1;
          state_nxt = S_DECIDE;
        end else if (idx_p1 == cnt_ext) begin
          found_nxt = 1'b0;
          state_nxt = S_DECIDE;
        end else begin
          idx_nxt = idx_p1[CNT_W-1:0];
        end
      end

      // act on the search outcome; rd_data still holds the hit entry
      S_DECIDE: begin
        state_nxt = S_EMIT;
        case (op_r)
          OP_ADD: begin
            if (found_r) begin
              res_st_nxt = ST_DUP;
            end else begin
              wr_en      = 1'b1;
              wr_addr    = cnt_r[AW-1:0];
              wr_data    = new_rec_r;
              cnt_nxt    = cnt_r + CNT_W'(1);
              res_st_nxt = ST_OK;
            end
          end
          OP_DELETE: begin
            if (!found_r) begin
              res_st_nxt = ST_MISS;
            end else if (idx_p1 < cnt_ext) begin
              state_nxt = S_SHIFT;
            end else begin
              cnt_nxt    = cnt_r - CNT_W'(1);
              res_st_nxt = ST_OK;
            end
          end
          OP_READ: begin
            if (found_r) begin
              res_rec_nxt = rd_data;
              res_st_nxt  = ST_OK;
            end else begin
              res_st_nxt = ST_MISS;
            end
          end
          default: begin
            if (found_r) begin
              res_rec_nxt.key = key_r;
              res_st_nxt      = ST_OK;
            end else begin
              res_st_nxt = ST_MISS;
            end
          end
        endcase
      end

      // move the following entry down one place per cycle
      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = idx_r[AW-1:0];
        wr_data = rd_data;
        if (idx_p2 < cnt_ext) begin
          idx_nxt = idx_p1[CNT_W-1:0];
        end else begin
          cnt_nxt    = cnt_r - CNT_W'(1);
          res_st_nxt = ST_OK;
          state_nxt  = S_EMIT;
        end
      end

      // single result of a non-list operation or of a list on an empty table
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_rec_nxt   = res_rec_r;
          out_cnt_nxt   = cnt_r;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      // one key per result, in stored order
      S_LIST: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_st_nxt      = ST_OK;
          out_rec_nxt     = '0;
          out_rec_nxt.key = rd_data.key;
          out_cnt_nxt     = cnt_r;
          out_last_nxt    = (idx_p1 == cnt_ext);
          if (idx_p1 == cnt_ext) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_p1[CNT_W-1:0];
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    new_rec_r  <= new_rec_nxt;
    res_rec_r  <= res_rec_nxt;
    res_st_r   <= res_st_nxt;
    found_r    <= found_nxt;
    out_st_r   <= out_st_nxt;
    out_rec_r  <= out_rec_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_last_r <= out_last_nxt;
  end

  // result channel
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_st_r;
  assign out_ch.out_key      = out_rec_r.key;
  assign out_ch.out_year     = out_rec_r.year;
  assign out_ch.out_course_a = out_rec_r.course_a;
  assign out_ch.out_grade_a  = out_rec_r.grade_a;
  assign out_ch.out_course_b = out_rec_r.course_b;
  assign out_ch.out_grade_b  = out_rec_r.grade_b;
  assign out_ch.out_course_c = out_rec_r.course_c;
  assign out_ch.out_grade_c  = out_rec_r.grade_c;
  assign out_ch.used_count   = out_cnt_r;
  assign out_ch.is_full      = (out_cnt_r == CNT_W'(CAPACITY));
  assign out_ch.last         = out_last_r;

endmodule

FILE: sv/ukrt_checker.sv
// port-level checker of the keyed record table, bound to the top level
// depends on ukrt_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ukrt_checker
  import ukrt_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [2:0]       out_status,
  input logic [31:0]      out_key,
  input logic [CNT_W-1:0] used_count,
  input logic             is_full,
  input logic             last
);

  // a stalled result holds still
  `ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_key) && $stable(out_status) && $stable(used_count) && $stable(last), "stalled result changed")

  // full flag agrees with the count
  `ASSERT_IMP(a_full_flag, clk, rst_n, out_valid, is_full == (used_count == CNT_W'(CAPACITY)), "is_full disagrees with used_count")

  // count never passes the capacity
  `ASSERT_IMP(a_cnt_range, clk, rst_n, out_valid, used_count <= CNT_W'(CAPACITY), "used_count above capacity")

  // only list results are non-final, and they are always ok
  `ASSERT_IMP(a_mid_ok, clk, rst_n, out_valid && !last, out_status == ST_OK, "non-final result with error status")

  // no new transaction is taken while a list is still streaming
  `ASSERT_IMP(a_list_busy, clk, rst_n, out_valid && !last, !in_ready, "input ready during a list")

endmodule

bind unique_key_record_table ukrt_checker #(
  .CAPACITY (CAPACITY)
) u_ukrt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_key    (out_ch.out_key),
  .used_count (out_ch.used_count),
  .is_full    (out_ch.is_full),
  .last       (out_ch.last)
);

FILE: sim/tb_top.sv
// self-checking testbench of the keyed record table: directed and random operations
// depends on ukrt_pkg, ukrt_in_if, ukrt_out_if and unique_key_record_table
`timescale 1ns / 1ps

module tb_top;
  import ukrt_pkg::*;

  localparam int CAPACITY     = CAPACITY_DEF;
  localparam int CNT_W        = CNT_W_DEF;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 60;
  localparam int IDLE_PCT     = 27;
  localparam int KEY_POOL_N   = 24;
  localparam int MAX_REPORTS  = 60;

  // kind codes the block drops without a result
  localparam logic [2:0] KIND_SPARE_A = 3'd6;
  localparam logic [2:0] KIND_SPARE_B = 3'd7;

  // one input transaction: operation plus the record fields it carries
  typedef struct packed {
    logic [2:0] kind;
    rec_t       rec;
  } op_item_t;

  // one expected result
  typedef struct packed {
    st_t              status;
    rec_t             rec;
    logic [CNT_W-1:0] used;
    logic             full;
    logic             last;
  } table_result_t;

  logic clk = 1'b0;
  logic rst_n;

  ukrt_in_if                   in_ch ();
  ukrt_out_if #(.CNT_W(CNT_W)) out_ch ();

  unique_key_record_table #(.CAPACITY(CAPACITY)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow copy of the table
  rec_t          stored_recs [CAPACITY];
  int unsigned   stored_count = 0;
  table_result_t pending_results [$];

  logic [31:0] key_pool [KEY_POOL_N];
  bit          steady = 1'b0;
  int          error_count = 0;
  int          result_index = 0;

  always #5 clk = ~clk;

  // mismatch reporting
  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("[%0t] result %0d: %s", $realtime, result_index, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report_error($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  function automatic int find_key(input logic [31:0] key);
    for (int i = 0; i < stored_count; i++) begin
      if (stored_recs[i].key == key) return i;
    end
    return -1;
  endfunction

  function automatic table_result_t make_result(input st_t status, input rec_t rec,
                                                input logic last);
    table_result_t r;
    r.status = status;
    r.rec    = rec;
    r.used   = stored_count[CNT_W-1:0];
    r.full   = (stored_count == CAPACITY);
    r.last   = last;
    return r;
  endfunction

  // update the shadow table and queue the results of one accepted transaction
  task automatic apply_op(input op_item_t it);
    int   slot;
    rec_t shown;
    slot  = find_key(it.rec.key);
    shown = '0;
    case (it.kind)
      OP_ADD: begin
        if (stored_count >= CAPACITY) begin
          pending_results.push_back(make_result(ST_FULL, shown, 1'b1));
        end else if (slot >= 0) begin
          pending_results.push_back(make_result(ST_DUP, shown, 1'b1));
        end else begin
          stored_recs[stored_count] = it.rec;
          stored_count++;
          pending_results.push_back(make_result(ST_OK, shown, 1'b1));
        end
      end
      OP_DELETE: begin
        if (slot < 0) begin
          pending_results.push_back(make_result(ST_MISS, shown, 1'b1));
        end else begin
          // later records move down one place
          for (int i = slot; i + 1 < stored_count; i++) stored_recs[i] = stored_recs[i + 1];
          stored_count--;
          pending_results.push_back(make_result(ST_OK, shown, 1'b1));
        end
      end
      OP_READ: begin
        if (slot < 0) begin
          pending_results.push_back(make_result(ST_MISS, shown, 1'b1));
        end else begin
          pending_results.push_back(make_result(ST_OK, stored_recs[slot], 1'b1));
        end
      end
      OP_EXISTS: begin
        if (slot < 0) begin
          pending_results.push_back(make_result(ST_MISS, shown, 1'b1));
        end else begin
          shown.key = it.rec.key;
          pending_results.push_back(make_result(ST_OK, shown, 1'b1));
        end
      end
      OP_LIST: begin
        if (stored_count == 0) begin
          pending_results.push_back(make_result(ST_EMPTY, shown, 1'b1));
        end else begin
          for (int i = 0; i < stored_count; i++) begin
            shown.key = stored_recs[i].key;
            pending_results.push_back(make_result(ST_OK, shown, i + 1 == stored_count));
          end
        end
      end
      OP_STATUS: pending_results.push_back(make_result(ST_OK, shown, 1'b1));
      default: ;
    endcase
  endtask

  // drive one transaction, with random idle cycles ahead of it unless steady is set
  task automatic send_op(input op_item_t it);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.kind     <= it.kind;
    in_ch.key      <= it.rec.key;
    in_ch.year     <= it.rec.year;
    in_ch.course_a <= it.rec.course_a;
    in_ch.grade_a  <= it.rec.grade_a;
    in_ch.course_b <= it.rec.course_b;
    in_ch.grade_b  <= it.rec.grade_b;
    in_ch.course_c <= it.rec.course_c;
    in_ch.grade_c  <= it.rec.grade_c;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    apply_op(it);
  endtask

  function automatic op_item_t make_op(input logic [2:0] kind, input rec_t rec);
    op_item_t it;
    it.kind = kind;
    it.rec  = rec;
    return it;
  endfunction

  function automatic rec_t random_rec(input logic [31:0] key);
    rec_t r;
    r.key      = key;
    r.year     = $urandom_range(0, 255);
    r.course_a = $urandom_range(0, 65535);
    r.grade_a  = $urandom_range(0, 255);
    r.course_b = $urandom_range(0, 65535);
    r.grade_b  = $urandom_range(0, 255);
    r.course_c = $urandom_range(0, 65535);
    r.grade_c  = $urandom_range(0, 255);
    return r;
  endfunction

  // mostly keys that hit the table or collide often, sometimes fully random
  function automatic logic [31:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (stored_count > 0 && r < 5) return stored_recs[$urandom_range(0, stored_count - 1)].key;
    if (r < 8) return key_pool[$urandom_range(0, KEY_POOL_N - 1)];
    return $urandom;
  endfunction

  function automatic logic [2:0] pick_kind(input int add_pct, input int del_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < add_pct) return OP_ADD;
    if (r < add_pct + del_pct) return OP_DELETE;
    case ($urandom_range(0, 9))
      0, 1, 2: return OP_READ;
      3, 4:    return OP_EXISTS;
      5, 6:    return OP_LIST;
      7:       return OP_STATUS;
      8:       return KIND_SPARE_A;
      default: return KIND_SPARE_B;
    endcase
  endfunction

  // every operation but add on an empty table
  task automatic test_empty_table();
    send_op(make_op(OP_LIST, random_rec($urandom)));
    send_op(make_op(OP_STATUS, random_rec($urandom)));
    send_op(make_op(OP_DELETE, random_rec($urandom)));
    send_op(make_op(OP_READ, random_rec($urandom)));
    send_op(make_op(OP_EXISTS, random_rec($urandom)));
  endtask

  // all-zero and all-one records, duplicate add, unused kinds
  task automatic test_field_extremes();
    rec_t low_rec;
    rec_t high_rec;
    low_rec  = '0;
    high_rec = '1;
    send_op(make_op(OP_ADD, low_rec));
    send_op(make_op(OP_ADD, high_rec));
    send_op(make_op(OP_ADD, random_rec(32'h0000_0000)));
    send_op(make_op(OP_READ, random_rec(32'hFFFF_FFFF)));
    send_op(make_op(OP_READ, random_rec(32'h0000_0000)));
    send_op(make_op(OP_EXISTS, random_rec(32'hFFFF_FFFF)));
    send_op(make_op(KIND_SPARE_A, random_rec(32'hFFFF_FFFF)));
    send_op(make_op(KIND_SPARE_B, random_rec(32'h0000_0000)));
    send_op(make_op(OP_DELETE, random_rec(32'h0000_0000)));
    send_op(make_op(OP_LIST, random_rec($urandom)));
    send_op(make_op(OP_DELETE, random_rec(32'hFFFF_FFFF)));
    send_op(make_op(OP_STATUS, random_rec($urandom)));
  endtask

  // fill to capacity, rejects on a full table, longest list, deletes at each end
  task automatic test_full_table();
    while (stored_count < CAPACITY) send_op(make_op(OP_ADD, random_rec($urandom)));
    send_op(make_op(OP_ADD, random_rec($urandom)));
    send_op(make_op(OP_ADD, random_rec(stored_recs[3].key)));
    send_op(make_op(OP_LIST, random_rec($urandom)));
    send_op(make_op(OP_READ, random_rec(stored_recs[CAPACITY - 1].key)));
    send_op(make_op(OP_DELETE, random_rec(stored_recs[7].key)));
    send_op(make_op(OP_ADD, random_rec($urandom)));
    send_op(make_op(OP_DELETE, random_rec(stored_recs[0].key)));
    send_op(make_op(OP_DELETE, random_rec(stored_recs[stored_count - 1].key)));
    send_op(make_op(OP_LIST, random_rec($urandom)));
  endtask

  // random mix; dropped kinds do not count toward the total
  task automatic test_random_ops(input int count, input int add_pct, input int del_pct);
    int       sent;
    op_item_t it;
    sent = 0;
    while (sent < count) begin
      it = make_op(pick_kind(add_pct, del_pct), random_rec(pick_key()));
      send_op(it);
      if (it.kind <= OP_STATUS) sent++;
    end
  endtask

  // result sink: random back-pressure, none while steady is set
  always @(negedge clk) begin
    out_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      table_result_t want;
      if (pending_results.size() == 0) begin
        report_error($sformatf("unexpected result, status %0h key %0h",
                               out_ch.status, out_ch.out_key));
      end else begin
        want = pending_results.pop_front();
        check_field("status", out_ch.status, want.status);
        check_field("out_key", out_ch.out_key, want.rec.key);
        check_field("out_year", out_ch.out_year, want.rec.year);
        check_field("out_course_a", out_ch.out_course_a, want.rec.course_a);
        check_field("out_grade_a", out_ch.out_grade_a, want.rec.grade_a);
        check_field("out_course_b", out_ch.out_course_b, want.rec.course_b);
        check_field("out_grade_b", out_ch.out_grade_b, want.rec.grade_b);
        check_field("out_course_c", out_ch.out_course_c, want.rec.course_c);
        check_field("out_grade_c", out_ch.out_grade_c, want.rec.grade_c);
        check_field("used_count", out_ch.used_count, want.used);
        check_field("is_full", out_ch.is_full, want.full);
        check_field("last", out_ch.last, want.last);
      end
      result_index++;
    end
  end

  // run limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.kind     = '0;
    in_ch.key      = '0;
    in_ch.year     = '0;
    in_ch.course_a = '0;
    in_ch.grade_a  = '0;
    in_ch.course_b = '0;
    in_ch.grade_b  = '0;
    in_ch.course_c = '0;
    in_ch.grade_c  = '0;
    out_ch.ready   = 1'b0;
    rst_n          = 1'b0;

    // small key pool so random adds collide and deletes hit
    for (int i = 0; i < KEY_POOL_N; i++) key_pool[i] = $urandom;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h0000_0001;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_field_extremes();
    test_full_table();
    test_random_ops(40, 60, 10);
    steady = 1'b1;
    test_random_ops(30, 35, 25);
    steady = 1'b0;
    test_random_ops(40, 35, 25);
    test_random_ops(25, 15, 50);

    @(negedge clk);
    in_ch.valid <= 1'b0;

    // let outstanding results drain, then a quiet tail
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/ukrt_pkg.sv
sv/ukrt_if.sv
sv/ukrt_rec_mem.sv
sv/unique_key_record_table.sv
sv/ukrt_checker.sv
sim/tb_top.sv
